>>> hdl/tfst_pkg.sv
// shared types and codes for the timed fade slot table
`timescale 1ns / 1ps
package tfst_pkg;

  // input operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_SNAP  = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  // most snapshot beats one tick may give
  localparam int MAX_RES = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_REJECT,
    ST_WALK,
    ST_LOAD,
    ST_CHK,
    ST_CLS,
    ST_DIV,
    ST_WB,
    ST_SCAN,
    ST_EMIT,
    ST_MARK
  } state_t;

endpackage

>>> hdl/tfst_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tfst_div.sv
// restoring divider for ramp fractions, one quotient bit per cycle
`timescale 1ns / 1ps
module tfst_div #(
  parameter int NW = 24,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CNTW = $clog2(QW + 1);

  logic [NW-1:0]   rem;
  logic [NW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic [NW:0]     r2;
  logic            fits;

  // one shift and trial subtract per step
  always_comb begin
    r2   = {rem, 1'b0};
    fits = (r2 >= {1'b0, dsr});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, numerator is below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? NW'(r2 - {1'b0, dsr}) : r2[NW-1:0];
      quo <= {quo[QW-2:0], fits};
    end
  end

endmodule

>>> hdl/timed_fade_slot_table_top.sv
// top level of the timed fade slot table
`timescale 1ns / 1ps
// Usage: one input channel (in_valid/in_ready) carries push, pop and tick
// beats; one output channel (out_valid/out_ready) carries result beats,
// with last marking the final beat of an input.
// Push gives one reply beat with the handle; pop gives no beat. Tick
// walks each used slot: one memory read, three check steps (load, check,
// classify) and a writeback, plus a run of the shared divider on a ramp;
// then each snapshot beat is chosen by a scan over the used slots (one
// slot per cycle from the slot memory read port).
// One input is worked at a time; in_ready is high only while idle, and
// the next beat is taken while the last result still sits in the output
// register. A stalled receiver holds the output register and the block.
// Reset clears live bits, free count and high water mark; no clearing
// pass is needed, since slot memory is read only for slots once written.
module timed_fade_slot_table_top #(
  parameter int SLOT_COUNT       = 16,
  parameter int TIME_BITS        = 24,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic [TIME_BITS-1:0]        fade_in_time,
  input  logic [TIME_BITS-1:0]        hold_time,
  input  logic [TIME_BITS-1:0]        fade_out_time,
  input  logic [7:0]                  entry_priority,
  input  logic                        has_payload,
  input  logic [3:0]                  pop_handle,
  input  logic [TIME_BITS-1:0]        delta_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  result_kind,
  output logic [3:0]                  slot_index,
  output logic [WEIGHT_FRAC_BITS:0]   blend_weight,
  output logic [7:0]                  out_priority,
  output logic                        accepted,
  output logic                        last
);

  import tfst_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int TW = TIME_BITS;
  localparam int EW = TIME_BITS + 2;
  localparam int WF = WEIGHT_FRAC_BITS;
  localparam int KW = 8 + SW;
  localparam int DW = 3 * TW + 9 + EW + WF + 1;
  // field offsets in a slot memory word
  localparam int O_EL = WF + 1;
  localparam int O_FL = O_EL + EW;
  localparam int O_PR = O_FL + 1;
  localparam int O_FO = O_PR + 8;
  localparam int O_HO = O_FO + TW;
  localparam int O_FI = O_HO + TW;

  localparam logic [WF:0] W_ONE = {1'b1, {WF{1'b0}}};

  state_t state, state_next;

  // control state
  logic [SLOT_COUNT-1:0] live;
  logic [SLOT_COUNT-1:0] cand;
  logic [CW-1:0]         free_count;
  logic [CW-1:0]         high_water;
  logic [CW-1:0]         widx;
  logic [CW-1:0]         sidx;
  logic [CW-1:0]         ncand;
  logic [4:0]            kcnt;
  logic [4:0]            ncap;
  logic                  pend;
  logic                  found;
  logic                  has_last;

  // payload registers
  logic [TW-1:0] lat_fi, lat_ho, lat_fo, lat_dt;
  logic [7:0]    lat_pr;
  logic          lat_fl;
  logic [SW-1:0] push_slot;
  logic [DW-1:0] ent;
  logic [EW-1:0] e_new;
  logic [EW-1:0] t1;
  logic          retire, zero_e, lt_fi, falling;
  logic [WF:0]   wreg;
  logic [SW-1:0] pidx;
  logic [KW-1:0] best_key, last_key;
  logic [WF:0]   best_w;

  // memory ports
  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic          fs_we;
  logic [SW-1:0] fs_waddr, fs_raddr, fs_wdata, fs_rdata;

  // divider
  logic          div_start, div_busy, div_done;
  logic [TW-1:0] div_num, div_den;
  logic [WF-1:0] div_quo;

  // misc combinational
  logic          in_acc, out_free, out_load;
  logic [1:0]    ld_kind;
  logic [3:0]    ld_slot;
  logic [WF:0]   ld_w;
  logic [7:0]    ld_pr;
  logic          ld_acc, ld_last;
  logic          pop_ok;
  logic [EW:0]   esum;
  logic [EW-1:0] total;
  logic [EW-1:0] t2;
  logic [KW-1:0] skey;
  logic          s_take;
  logic [WF:0]   cls_w;

  tfst_ram #(.WIDTH(DW), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tfst_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  tfst_div #(.NW(TW), .QW(WF)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pop_ok   = (32'(pop_handle) < 32'(high_water)) && live[SW'(pop_handle)];

  // per-slot arithmetic
  always_comb begin
    esum  = {1'b0, ram_rdata[O_EL +: EW]} + (EW + 1)'(lat_dt);
    total = EW'(ent[O_FI +: TW]) + EW'(ent[O_HO +: TW]) + EW'(ent[O_FO +: TW]);
    t2    = t1 - EW'(ent[O_HO +: TW]);
    skey  = {ram_rdata[O_PR +: 8], pidx};
    s_take = pend && cand[pidx] && (!has_last || (skey > last_key)) &&
             (!found || (skey < best_key));
    cls_w = W_ONE;
    if (retire) begin
      cls_w = '0;
    end else if (zero_e) begin
      cls_w = (ent[O_FI +: TW] != '0) ? '0 : W_ONE;
    end else if (t2 >= EW'(ent[O_FO +: TW]) && !lt_fi &&
                 (t1 >= EW'(ent[O_HO +: TW]))) begin
      cls_w = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode)
            OP_PUSH: begin
              if (free_count != '0) begin
                state_next = ST_PUSH_RD;
              end else if (32'(high_water) < SLOT_COUNT) begin
                state_next = ST_PUSH_WR;
              end else begin
                state_next = ST_REJECT;
              end
            end
            OP_TICK: state_next = ST_WALK;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PUSH_RD: state_next = ST_PUSH_WR;
      ST_PUSH_WR, ST_REJECT, ST_MARK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (widx >= high_water) begin
          state_next = (ncand == '0) ? ST_MARK : ST_SCAN;
        end else if (live[widx[SW-1:0]]) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_CHK;
      ST_CHK:  state_next = ST_CLS;
      ST_CLS: begin
        if (!retire && !zero_e &&
            (lt_fi || ((t1 >= EW'(ent[O_HO +: TW])) &&
                       (t2 < EW'(ent[O_FO +: TW]))))) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_WB;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_WB;
        end
      end
      ST_WB: state_next = ST_WALK;
      ST_SCAN: begin
        if ((sidx >= high_water) && !pend) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (kcnt + 5'd1 == ncap) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory, divider and output load controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx[SW-1:0];
    ram_wdata = {ent[O_FI +: TW], ent[O_HO +: TW], ent[O_FO +: TW], ent[O_PR +: 8],
                 ent[O_FL], e_new, wreg};
    ram_raddr = widx[SW-1:0];
    fs_we     = 1'b0;
    fs_waddr  = SW'(free_count);
    fs_wdata  = widx[SW-1:0];
    fs_raddr  = SW'(free_count - 1'b1);
    div_start = 1'b0;
    div_num   = lt_fi ? e_new[TW-1:0] : t2[TW-1:0];
    div_den   = lt_fi ? ent[O_FI +: TW] : ent[O_FO +: TW];
    out_load  = 1'b0;
    ld_kind   = KIND_REPLY;
    ld_slot   = '0;
    ld_w      = '0;
    ld_pr     = '0;
    ld_acc    = 1'b0;
    ld_last   = 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_acc && (opcode == OP_POP) && pop_ok && (32'(free_count) < SLOT_COUNT)) begin
          fs_we    = 1'b1;
          fs_wdata = SW'(pop_handle);
        end
      end
      ST_PUSH_WR: begin
        ram_waddr = push_slot;
        ram_wdata = {lat_fi, lat_ho, lat_fo, lat_pr, lat_fl, {EW{1'b0}}, {(WF + 1){1'b0}}};
        if (out_free) begin
          ram_we   = 1'b1;
          out_load = 1'b1;
          ld_slot  = 4'(push_slot);
          ld_acc   = 1'b1;
        end
      end
      ST_REJECT: out_load = out_free;
      ST_MARK: begin
        out_load = out_free;
        ld_kind  = KIND_MARK;
      end
      ST_CLS: div_start = (state_next == ST_DIV);
      ST_WB: begin
        ram_we = 1'b1;
        fs_we  = retire && (32'(free_count) < SLOT_COUNT);
      end
      ST_SCAN: ram_raddr = sidx[SW-1:0];
      ST_EMIT: begin
        out_load = out_free;
        ld_kind  = KIND_SNAP;
        ld_slot  = 4'(best_key[SW-1:0]);
        ld_w     = best_w;
        ld_pr    = best_key[KW-1:SW];
        ld_last  = (kcnt + 5'd1 == ncap);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      live       <= '0;
      cand       <= '0;
      free_count <= '0;
      high_water <= '0;
      widx       <= '0;
      sidx       <= '0;
      ncand      <= '0;
      kcnt       <= '0;
      ncap       <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      has_last   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && (opcode == OP_PUSH)) begin
            if (free_count != '0) begin
              free_count <= free_count - 1'b1;
            end else if (32'(high_water) < SLOT_COUNT) begin
              high_water <= high_water + 1'b1;
            end
          end
          if (in_acc && (opcode == OP_POP) && pop_ok) begin
            live[SW'(pop_handle)] <= 1'b0;
            if (32'(free_count) < SLOT_COUNT) begin
              free_count <= free_count + 1'b1;
            end
          end
          if (in_acc && (opcode == OP_TICK)) begin
            cand  <= '0;
            ncand <= '0;
            widx  <= '0;
          end
        end
        ST_PUSH_WR: begin
          if (out_free) begin
            live[push_slot] <= 1'b1;
          end
        end
        ST_WALK: begin
          if (widx >= high_water) begin
            ncap     <= (32'(ncand) > MAX_RES) ? 5'(MAX_RES) : 5'(ncand);
            kcnt     <= '0;
            has_last <= 1'b0;
            sidx     <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
          end else if (!live[widx[SW-1:0]]) begin
            widx <= widx + 1'b1;
          end
        end
        ST_WB: begin
          widx <= widx + 1'b1;
          if (retire) begin
            live[widx[SW-1:0]] <= 1'b0;
            if (32'(free_count) < SLOT_COUNT) begin
              free_count <= free_count + 1'b1;
            end
          end else if ((wreg != '0) && ent[O_FL]) begin
            cand[widx[SW-1:0]] <= 1'b1;
            ncand <= ncand + 1'b1;
          end
        end
        ST_SCAN: begin
          pend <= (sidx < high_water);
          if (sidx < high_water) begin
            sidx <= sidx + 1'b1;
          end
          if (s_take) begin
            found <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            kcnt     <= kcnt + 5'd1;
            has_last <= 1'b1;
            sidx     <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lat_fi <= fade_in_time;
      lat_ho <= hold_time;
      lat_fo <= fade_out_time;
      lat_pr <= entry_priority;
      lat_fl <= has_payload;
      lat_dt <= delta_time;
      push_slot <= SW'(high_water);
    end
    if (state == ST_PUSH_RD) begin
      push_slot <= fs_rdata;
    end
    // saturating elapsed update
    if (state == ST_LOAD) begin
      ent   <= ram_rdata;
      e_new <= esum[EW] ? {EW{1'b1}} : esum[EW-1:0];
    end
    if (state == ST_CHK) begin
      retire <= (e_new >= total);
      zero_e <= (e_new == '0);
      lt_fi  <= (e_new < EW'(ent[O_FI +: TW]));
      t1     <= e_new - EW'(ent[O_FI +: TW]);
    end
    if (state == ST_CLS) begin
      wreg    <= cls_w;
      falling <= !lt_fi;
    end
    if ((state == ST_DIV) && div_done) begin
      wreg <= falling ? (W_ONE - {1'b0, div_quo}) : {1'b0, div_quo};
    end
    // scan winner tracking
    if (state == ST_SCAN) begin
      pidx <= sidx[SW-1:0];
      if (s_take) begin
        best_key <= skey;
        best_w   <= ram_rdata[WF:0];
      end
    end
    if ((state == ST_EMIT) && out_free) begin
      last_key <= best_key;
    end
    // output register
    if (out_load) begin
      result_kind  <= ld_kind;
      slot_index   <= ld_slot;
      blend_weight <= ld_w;
      out_priority <= ld_pr;
      accepted     <= ld_acc;
      last         <= ld_last;
    end
  end

  // checks
  a_free_le_hw: assert property (@(posedge clk) disable iff (rst)
    free_count <= high_water)
    else $error("free count above high water");

  a_hw_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> high_water >= $past(high_water))
    else $error("high water decreased");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV)
    else $error("divider busy outside ramp state");

  a_mark_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_MARK)) |-> last)
    else $error("empty marker without last");

endmodule

>>> verif/timed_fade_slot_table_top_test.sv
// self-checking testbench for the timed fade slot table
`timescale 1ns / 1ps
module timed_fade_slot_table_top_test;
  import tfst_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [25:0] ELAPSED_SAT = 26'h3FFFFFF;
  localparam logic [16:0] W_FULL = 17'h10000;
  localparam logic [1:0] OP_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] fin;
    logic [23:0] hld;
    logic [23:0] fout;
    logic [7:0]  prio;
    logic        pay;
    logic [3:0]  handle;
    logic [23:0] dt;
  } op_beat_t;

  localparam int OPW = $bits(op_beat_t);

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [16:0] weight;
    logic [7:0]  prio;
    logic        acc;
    logic        lst;
  } res_beat_t;

  typedef struct {
    op_beat_t  beat;
    bit        typed;
    res_beat_t want;
  } table_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] opcode, result_kind;
  logic [23:0] fade_in_time, hold_time, fade_out_time, delta_time;
  logic [7:0] entry_priority, out_priority;
  logic has_payload, accepted, last;
  logic [3:0] pop_handle, slot_index;
  logic [16:0] blend_weight;

  timed_fade_slot_table_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .fade_in_time(fade_in_time), .hold_time(hold_time),
    .fade_out_time(fade_out_time), .entry_priority(entry_priority),
    .has_payload(has_payload), .pop_handle(pop_handle), .delta_time(delta_time),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .slot_index(slot_index), .blend_weight(blend_weight),
    .out_priority(out_priority), .accepted(accepted), .last(last)
  );

  // shadow slot table
  bit          live_q[NSLOT];
  logic [23:0] fin_q[NSLOT], hld_q[NSLOT], fout_q[NSLOT];
  logic [7:0]  prio_q[NSLOT];
  bit          pay_q[NSLOT];
  logic [25:0] elapsed_q[NSLOT];
  logic [3:0]  free_stk[NSLOT];
  int          free_cnt, high_water;

  res_beat_t pending_results[$];
  int mismatches = 0;
  longint cycles = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  function automatic res_beat_t mk(logic [1:0] k, logic [3:0] s, logic [16:0] w,
                                   logic [7:0] p, logic a, logic l);
    res_beat_t r;
    r.kind = k; r.slot = s; r.weight = w; r.prio = p; r.acc = a; r.lst = l;
    return r;
  endfunction

  function automatic logic [16:0] blend_of(int s);
    logic [25:0] e;
    logic [63:0] t;
    e = elapsed_q[s];
    if (e == 0) return (fin_q[s] != 0) ? 17'd0 : W_FULL;
    if (e < fin_q[s]) return 17'((64'(e) << 16) / fin_q[s]);
    t = 64'(e) - fin_q[s];
    if (t < hld_q[s]) return W_FULL;
    t = t - hld_q[s];
    if (t < fout_q[s]) return 17'(64'(W_FULL) - ((t << 16) / fout_q[s]));
    return 17'd0;
  endfunction

  function automatic void release_slot(int s);
    live_q[s] = 0;
    if (free_cnt < NSLOT) begin
      free_stk[free_cnt] = 4'(s);
      free_cnt++;
    end
  endfunction

  // work out the result beats of one accepted input beat
  task automatic predict_table(op_beat_t b);
    int s, n, j;
    int order[NSLOT];
    logic [16:0] wts[NSLOT];
    logic [16:0] w;
    logic [26:0] sum;
    logic [25:0] total;
    n = 0;
    case (b.op)
      OP_PUSH: begin
        s = -1;
        if (free_cnt > 0) begin
          free_cnt--;
          s = free_stk[free_cnt];
        end else if (high_water < NSLOT) begin
          s = high_water;
          high_water++;
        end
        if (s < 0) begin
          pending_results.insert(pending_results.size(), mk(KIND_REPLY, 0, 0, 0, 0, 1));
        end else begin
          live_q[s] = 1; fin_q[s] = b.fin; hld_q[s] = b.hld; fout_q[s] = b.fout;
          prio_q[s] = b.prio; pay_q[s] = b.pay; elapsed_q[s] = 0;
          pending_results.insert(pending_results.size(),
                                 mk(KIND_REPLY, 4'(s), 0, 0, 1, 1));
        end
      end
      OP_POP: begin
        if (b.handle < high_water && live_q[b.handle]) release_slot(b.handle);
      end
      OP_TICK: begin
        for (int i = 0; i < high_water; i++) begin
          if (!live_q[i]) continue;
          sum = 27'(elapsed_q[i]) + b.dt;
          elapsed_q[i] = (sum > ELAPSED_SAT) ? ELAPSED_SAT : sum[25:0];
          total = 26'(fin_q[i]) + hld_q[i] + fout_q[i];
          if (elapsed_q[i] >= total) begin
            release_slot(i);
            continue;
          end
          w = blend_of(i);
          if (w == 0 || !pay_q[i]) continue;
          // stable insertion by priority
          j = n;
          while (j > 0 && prio_q[order[j-1]] > prio_q[i]) begin
            order[j] = order[j-1];
            wts[j] = wts[j-1];
            j--;
          end
          order[j] = i;
          wts[j] = w;
          n++;
        end
        if (n == 0)
          pending_results.insert(pending_results.size(), mk(KIND_MARK, 0, 0, 0, 0, 1));
        for (int k = 0; k < n; k++)
          pending_results.insert(pending_results.size(),
                                 mk(KIND_SNAP, 4'(order[k]), wts[k],
                                    prio_q[order[k]], 0, k == n - 1));
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    res_beat_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = mk(result_kind, slot_index, blend_weight, out_priority, accepted, last);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int waits;
    out_ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (waits > 0) begin
        out_ready <= 0;
        repeat (waits) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(op_beat_t b, bit gaps);
    int waits;
    waits = gaps ? $urandom_range(0, 12) : 0;
    if (waits > 0) begin
      in_valid <= 0;
      repeat (waits) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= b.op; fade_in_time <= b.fin; hold_time <= b.hld;
    fade_out_time <= b.fout; entry_priority <= b.prio; has_payload <= b.pay;
    pop_handle <= b.handle; delta_time <= b.dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table(b);
  endtask

  function automatic op_beat_t push_of(logic [23:0] fi, logic [23:0] h,
                                       logic [23:0] fo, logic [7:0] p, logic pay);
    op_beat_t b;
    b = '0;
    b.op = OP_PUSH; b.fin = fi; b.hld = h; b.fout = fo; b.prio = p; b.pay = pay;
    b.handle = 4'($urandom); b.dt = 24'($urandom);
    return b;
  endfunction

  function automatic op_beat_t pop_of(logic [3:0] h);
    op_beat_t b;
    b = op_beat_t'(OPW'({$urandom, $urandom, $urandom, $urandom}));
    b.op = OP_POP; b.handle = h;
    return b;
  endfunction

  function automatic op_beat_t tick_of(logic [23:0] dt);
    op_beat_t b;
    b = op_beat_t'(OPW'({$urandom, $urandom, $urandom, $urandom}));
    b.op = OP_TICK; b.dt = dt;
    return b;
  endfunction

  function automatic logic [23:0] rand_time();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 16));
      3: return 24'($urandom);
      default: return 24'($urandom_range(1, 24'h40000));
    endcase
  endfunction

  table_row_t rows[$];

  // stimulus
  initial begin
    table_row_t r;
    op_beat_t b;
    int pick;
    rst = 1; in_valid = 0; opcode = OP_PUSH; fade_in_time = 0; hold_time = 0;
    fade_out_time = 0; entry_priority = 0; has_payload = 0; pop_handle = 0;
    delta_time = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed table
    r.typed = 1; r.beat = tick_of(24'hFFFFFF); r.want = mk(KIND_MARK, 0, 0, 0, 0, 1);
    rows.insert(rows.size(), r);
    r.typed = 0; r.beat = pop_of(4'd0); rows.insert(rows.size(), r);
    r.typed = 0; r.beat = op_beat_t'('0); r.beat.op = OP_BAD; rows.insert(rows.size(), r);
    r.typed = 1;
    r.beat = push_of(24'd0, 24'd0, 24'd0, 8'd0, 1);
    r.want = mk(KIND_REPLY, 0, 0, 0, 1, 1); rows.insert(rows.size(), r);
    r.beat = push_of(24'd0, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1);
    r.want = mk(KIND_REPLY, 1, 0, 0, 1, 1); rows.insert(rows.size(), r);
    r.beat = push_of(24'h10000, 24'h10000, 24'h10000, 8'h80, 1);
    r.want = mk(KIND_REPLY, 2, 0, 0, 1, 1); rows.insert(rows.size(), r);
    r.beat = push_of(24'hFFFFFF, 24'd0, 24'd5, 8'h80, 0);
    r.want = mk(KIND_REPLY, 3, 0, 0, 1, 1); rows.insert(rows.size(), r);
    r.typed = 0;
    r.beat = tick_of(24'd0); rows.insert(rows.size(), r);
    r.beat = tick_of(24'h8000); rows.insert(rows.size(), r);
    r.beat = tick_of(24'h10000); rows.insert(rows.size(), r);
    r.beat = pop_of(4'd1); rows.insert(rows.size(), r);
    r.beat = pop_of(4'd1); rows.insert(rows.size(), r);
    r.beat = pop_of(4'd15); rows.insert(rows.size(), r);
    r.beat = tick_of(24'hFFFFFF); rows.insert(rows.size(), r);
    r.beat = tick_of(24'hFFFFFF); rows.insert(rows.size(), r);
    r.beat = tick_of(24'hFFFFFF); rows.insert(rows.size(), r);
    for (int i = 0; i < 17; i++) begin
      r.beat = push_of(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'(i % 3), 1);
      rows.insert(rows.size(), r);
    end
    r.beat = tick_of(24'd1); rows.insert(rows.size(), r);

    foreach (rows[i]) begin
      if (rows[i].typed) pending_results.insert(pending_results.size(), rows[i].want);
      else predict_table(rows[i].beat);
      // typed rows carry their own expectation; predict anyway to keep state and check it
      if (rows[i].typed) begin
        pending_results.delete(pending_results.size() - 1);
        predict_table(rows[i].beat);
        if (pending_results[$] !== rows[i].want) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d expectation disagrees", i);
        end
      end
    end
    // rewind the shadow state and replay through the block
    pending_results.delete();
    foreach (live_q[i]) live_q[i] = 0;
    free_cnt = 0; high_water = 0;
    foreach (rows[i]) send_beat(rows[i].beat, (i % 2) == 1);

    // long receiver stall while the sender keeps going
    hold_off = 1;
    for (int i = 0; i < 446; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) b = push_of(rand_time(), rand_time(), rand_time(),
                                 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                                 $urandom_range(0, 4) != 0);
      else if (pick < 62) b = pop_of(($urandom_range(0, 3) == 0) ? 4'($urandom)
                                     : 4'($urandom_range(0, high_water > 0 ? high_water - 1 : 0)));
      else if (pick < 98) b = tick_of(rand_time() >> $urandom_range(0, 8));
      else begin
        b = op_beat_t'(OPW'({$urandom, $urandom, $urandom, $urandom}));
        b.op = OP_BAD;
      end
      send_beat(b, $urandom_range(0, 2) != 0);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // end of run and timeout
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0 && cycles < 2000000) @(posedge clk);
    repeat (700) @(posedge clk);
    if (cycles >= 2000000) $display("timed_fade_slot_table_top verification failed");
    else if (mismatches == 0 && pending_results.size() == 0)
      $display("timed_fade_slot_table_top verification clean");
    else $display("timed_fade_slot_table_top verification failed");
    $finish;
  end

  initial begin
    wait (cycles >= 2500000);
    $display("timed_fade_slot_table_top verification failed");
    $finish;
  end

endmodule
